[design/clp_pkg.sv]
// Shared types and constants for the CAN log line parser.
package clp_pkg;

	// Largest length accepted inside the brackets
	localparam logic [3:0] MAX_LEN = 4'd8;

	// Largest standard identifier
	localparam logic [31:0] ID_STD_MAX = 32'h0000_07FF;

	// Identifier token length limit
	localparam logic [3:0] ID_TOK_MAX = 4'd15;

	// Identifier tokens longer than this are extended
	localparam logic [3:0] ID_STD_TOK = 4'd3;

	// Character queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_LBR  = 8'h5B;
	localparam logic [7:0] CH_RBR  = 8'h5D;
	localparam logic [7:0] CH_XLO  = 8'h78;
	localparam logic [7:0] CH_XUP  = 8'h58;

	// One classified character word
	typedef struct packed {
		logic       eol;
		logic       ws;
		logic       hex;
		logic       dec;
		logic       x;
		logic       hash;
		logic       lbr;
		logic       rbr;
		logic [3:0] val;
	} tok_t;

endpackage

[design/clp_front.sv]
// Front end: takes characters, classifies them, and feeds the token queue.
module clp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    char_code,
	input  logic          line_end,
	input  logic          line_valid,
	output logic          line_ready,
	input  logic          q_full,
	output logic          push,
	output clp_pkg::tok_t tok_s1
);

	logic          valid_s1;
	clp_pkg::tok_t tok_c;

	always_comb begin
		tok_c = '0;
		tok_c.eol  = line_end;
		tok_c.ws   = (char_code == 8'd32) || (char_code >= 8'd9 && char_code <= 8'd13);
		tok_c.x    = (char_code == clp_pkg::CH_XLO) || (char_code == clp_pkg::CH_XUP);
		tok_c.hash = (char_code == clp_pkg::CH_HASH);
		tok_c.lbr  = (char_code == clp_pkg::CH_LBR);
		tok_c.rbr  = (char_code == clp_pkg::CH_RBR);
		if (char_code >= 8'h30 && char_code <= 8'h39) begin
			tok_c.hex = 1'b1;
			tok_c.dec = 1'b1;
			tok_c.val = 4'(char_code - 8'h30);
		end else if (char_code >= 8'h61 && char_code <= 8'h66) begin
			tok_c.hex = 1'b1;
			tok_c.val = 4'(char_code - 8'h57);
		end else if (char_code >= 8'h41 && char_code <= 8'h46) begin
			tok_c.hex = 1'b1;
			tok_c.val = 4'(char_code - 8'h37);
		end
	end

	assign push       = valid_s1 && !q_full;
	assign line_ready = !valid_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line_ready) begin
			valid_s1 <= line_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (line_ready && line_valid) begin
			tok_s1 <= tok_c;
		end
	end

endmodule

[design/clp_queue.sv]
// Short FIFO of classified character words between front and back.
module clp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  clp_pkg::tok_t push_tok,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output clp_pkg::tok_t head_tok
);

	clp_pkg::tok_t                mem_q [clp_pkg::QDEPTH];
	logic [clp_pkg::QAW-1:0]      wr_ptr_q;
	logic [clp_pkg::QAW-1:0]      rd_ptr_q;
	logic [clp_pkg::QAW:0]        count_q;

	assign full       = (count_q == (clp_pkg::QAW+1)'(clp_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_tok   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule

[design/clp_back.sv]
// Back end: line parser state machine and the result output register.
module clp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  clp_pkg::tok_t head_tok,
	output logic          pop,
	output logic          result_valid,
	input  logic          result_ready,
	output logic          frame_valid,
	output logic [31:0]   frame_id,
	output logic          is_extended,
	output logic [3:0]    byte_count,
	output logic [63:0]   payload
);

	localparam logic [3:0] P_LEAD      = 4'd0;
	localparam logic [3:0] P_IFACE     = 4'd1;
	localparam logic [3:0] P_GAP1      = 4'd2;
	localparam logic [3:0] P_ID_PREFIX = 4'd3;
	localparam logic [3:0] P_ID_DIG    = 4'd4;
	localparam logic [3:0] P_ID_STOP   = 4'd5;
	localparam logic [3:0] P_GAP2      = 4'd6;
	localparam logic [3:0] P_LEN_GAP   = 4'd7;
	localparam logic [3:0] P_LEN_DIG   = 4'd8;
	localparam logic [3:0] P_LEN_CLOSE = 4'd9;
	localparam logic [3:0] P_B_GAP     = 4'd10;
	localparam logic [3:0] P_B_ZERO    = 4'd11;
	localparam logic [3:0] P_B_PREFIX  = 4'd12;
	localparam logic [3:0] P_B_DIG     = 4'd13;
	localparam logic [3:0] P_DONE      = 4'd14;

	logic [3:0]  phase_q, phase_d;
	logic [31:0] id_q, id_d;
	logic [3:0]  idlen_q, idlen_d;
	logic [3:0]  len_q, len_d;
	logic [3:0]  bidx_q, bidx_d;
	logic [7:0]  bacc_q, bacc_d;
	logic [63:0] data_q, data_d;
	logic        err_q, err_d;

	logic        out_free;
	logic        take_eol;

	// byte store helper signals
	logic [7:0]  fin_byte;
	logic        do_fin;
	logic [63:0] data_fin;
	logic        fin_done;
	logic [3:0]  bidx_inc;
	logic [6:0]  len_x10;

	// end-of-line result
	logic        res_valid;
	logic        in_byte;

	assign out_free = !result_valid || result_ready;
	assign pop      = head_valid && (!head_tok.eol || out_free);
	assign take_eol = pop && head_tok.eol;

	assign in_byte  = (phase_q == P_B_ZERO) || (phase_q == P_B_DIG) ||
		(phase_q == P_B_PREFIX);
	assign bidx_inc = bidx_q + 4'd1;
	assign fin_done = ({1'b0, bidx_q} + 5'd1) >= {1'b0, len_q};
	assign len_x10  = {len_q, 3'b000} + {2'b00, len_q, 1'b0};

	always_comb begin
		data_fin = data_q;
		for (int i = 0; i < 8; i++) begin
			if (bidx_q[2:0] == 3'(i)) begin
				data_fin[8*i +: 8] = data_q[8*i +: 8] | fin_byte;
			end
		end
	end

	always_comb begin
		phase_d  = phase_q;
		id_d     = id_q;
		idlen_d  = idlen_q;
		len_d    = len_q;
		bidx_d   = bidx_q;
		bacc_d   = bacc_q;
		data_d   = data_q;
		err_d    = err_q;
		fin_byte = bacc_q;
		do_fin   = 1'b0;

		unique case (phase_q)
			P_LEAD: begin
				if (!head_tok.ws) begin
					if (head_tok.hash) begin
						err_d   = 1'b1;
						phase_d = P_DONE;
					end else begin
						phase_d = P_IFACE;
					end
				end
			end
			P_IFACE: begin
				if (head_tok.ws) begin
					phase_d = P_GAP1;
				end
			end
			P_GAP1: begin
				if (!head_tok.ws) begin
					if (!head_tok.hex) begin
						err_d   = 1'b1;
						phase_d = P_DONE;
					end else begin
						idlen_d = 4'd1;
						id_d    = {28'd0, head_tok.val};
						phase_d = P_ID_DIG;
					end
				end
			end
			P_ID_PREFIX, P_ID_DIG, P_ID_STOP: begin
				if (head_tok.ws) begin
					phase_d = P_GAP2;
				end else if (idlen_q >= clp_pkg::ID_TOK_MAX) begin
					err_d   = 1'b1;
					phase_d = P_DONE;
				end else begin
					idlen_d = idlen_q + 4'd1;
					if (phase_q == P_ID_DIG) begin
						if (head_tok.hex) begin
							if (id_q[31:28] != 4'd0) begin
								err_d   = 1'b1;
								phase_d = P_DONE;
							end else begin
								id_d = {id_q[27:0], head_tok.val};
							end
						end else if (head_tok.x && idlen_q == 4'd1 && id_q == '0) begin
							phase_d = P_ID_PREFIX;
						end else begin
							phase_d = P_ID_STOP;
						end
					end else if (phase_q == P_ID_PREFIX) begin
						if (head_tok.hex) begin
							id_d    = {28'd0, head_tok.val};
							phase_d = P_ID_DIG;
						end else begin
							phase_d = P_ID_STOP;
						end
					end
				end
			end
			P_GAP2: begin
				if (!head_tok.ws) begin
					if (head_tok.lbr) begin
						phase_d = P_LEN_GAP;
					end else begin
						err_d   = 1'b1;
						phase_d = P_DONE;
					end
				end
			end
			P_LEN_GAP: begin
				if (!head_tok.ws) begin
					if (head_tok.dec && head_tok.val <= clp_pkg::MAX_LEN) begin
						len_d   = head_tok.val;
						phase_d = P_LEN_DIG;
					end else begin
						err_d   = 1'b1;
						phase_d = P_DONE;
					end
				end
			end
			P_LEN_DIG: begin
				if (head_tok.dec) begin
					if ((len_x10 + {3'd0, head_tok.val}) > {3'd0, clp_pkg::MAX_LEN}) begin
						err_d   = 1'b1;
						phase_d = P_DONE;
					end else begin
						len_d = 4'(len_x10 + {3'd0, head_tok.val});
					end
				end else if (head_tok.rbr) begin
					phase_d = (len_q == 4'd0) ? P_DONE : P_B_GAP;
				end else if (head_tok.ws) begin
					phase_d = P_LEN_CLOSE;
				end else begin
					err_d   = 1'b1;
					phase_d = P_DONE;
				end
			end
			P_LEN_CLOSE: begin
				if (!head_tok.ws) begin
					if (head_tok.rbr) begin
						phase_d = (len_q == 4'd0) ? P_DONE : P_B_GAP;
					end else begin
						err_d   = 1'b1;
						phase_d = P_DONE;
					end
				end
			end
			P_B_GAP: begin
				if (!head_tok.ws) begin
					if (!head_tok.hex) begin
						err_d   = 1'b1;
						phase_d = P_DONE;
					end else begin
						bacc_d  = {4'd0, head_tok.val};
						phase_d = (head_tok.val == 4'd0) ? P_B_ZERO : P_B_DIG;
					end
				end
			end
			P_B_ZERO, P_B_DIG: begin
				if (head_tok.hex) begin
					bacc_d  = {bacc_q[3:0], head_tok.val};
					phase_d = P_B_DIG;
				end else if (phase_q == P_B_ZERO && head_tok.x) begin
					phase_d = P_B_PREFIX;
				end else begin
					do_fin = 1'b1;
					if (fin_done) begin
						phase_d = P_DONE;
					end else if (head_tok.ws) begin
						phase_d = P_B_GAP;
					end else begin
						err_d   = 1'b1;
						phase_d = P_DONE;
					end
				end
			end
			P_B_PREFIX: begin
				if (head_tok.hex) begin
					bacc_d  = {4'd0, head_tok.val};
					phase_d = P_B_DIG;
				end else begin
					bacc_d   = 8'd0;
					fin_byte = 8'd0;
					do_fin   = 1'b1;
					phase_d  = P_DONE;
					if (!fin_done) begin
						err_d = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		if (do_fin) begin
			data_d = data_fin;
			bidx_d = bidx_inc;
		end

		// End of line closes any byte still open and judges the line
		if (head_tok.eol) begin
			fin_byte = (phase_q == P_B_PREFIX) ? 8'd0 : bacc_q;
		end
	end

	always_comb begin
		if (!err_q && in_byte) begin
			res_valid = fin_done;
		end else begin
			res_valid = !err_q && (phase_q == P_DONE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= P_LEAD;
			id_q         <= '0;
			idlen_q      <= '0;
			len_q        <= '0;
			bidx_q       <= '0;
			bacc_q       <= '0;
			data_q       <= '0;
			err_q        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (take_eol) begin
				phase_q <= P_LEAD;
				id_q    <= '0;
				idlen_q <= '0;
				len_q   <= '0;
				bidx_q  <= '0;
				bacc_q  <= '0;
				data_q  <= '0;
				err_q   <= 1'b0;
			end else if (pop) begin
				phase_q <= phase_d;
				id_q    <= id_d;
				idlen_q <= idlen_d;
				len_q   <= len_d;
				bidx_q  <= bidx_d;
				bacc_q  <= bacc_d;
				data_q  <= data_d;
				err_q   <= err_d;
			end
			if (take_eol) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	// Result fields; all zero for a line that did not parse
	always_ff @(posedge clk) begin
		if (take_eol) begin
			frame_valid <= res_valid;
			if (res_valid) begin
				frame_id    <= id_q;
				is_extended <= (idlen_q > clp_pkg::ID_STD_TOK) ||
					(id_q > clp_pkg::ID_STD_MAX);
				byte_count  <= len_q;
				payload     <= (!err_q && in_byte) ? data_fin : data_q;
			end else begin
				frame_id    <= '0;
				is_extended <= 1'b0;
				byte_count  <= '0;
				payload     <= '0;
			end
		end
	end

endmodule

[design/can_log_line_parser.sv]
// Top level of the CAN log text line parser: front, token queue and back.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+--------------------------------------
//   line in  | line_valid / line_ready     | char_code, line_end
//   result   | result_valid / result_ready | frame_valid, frame_id, is_extended,
//            |                             | byte_count, payload
//
// One character word per cycle sustained while the queue is not full. A word
// passes the classify register, the 4-entry token queue and the parser state
// machine; a result is registered when the back pops its line_end word.
// The back stalls only on a line_end word while the result register is full;
// the queue absorbs that so the input side keeps going until it fills.
// Reset (arst_n low) empties the queue and returns the parser to line start.
module can_log_line_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  char_code,
	input  logic        line_end,
	input  logic        line_valid,
	output logic        line_ready,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        frame_valid,
	output logic [31:0] frame_id,
	output logic        is_extended,
	output logic [3:0]  byte_count,
	output logic [63:0] payload
);

	// front to queue
	logic          push;
	logic          q_full;
	clp_pkg::tok_t tok_s1;

	// queue to back
	logic          pop;
	logic          head_valid;
	clp_pkg::tok_t head_tok;

	// Classify each character into a token word
	clp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_code  (char_code),
		.line_end   (line_end),
		.line_valid (line_valid),
		.line_ready (line_ready),
		.q_full     (q_full),
		.push       (push),
		.tok_s1     (tok_s1)
	);

	// Decouples the front from stalls on the result side
	clp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_tok   (tok_s1),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_tok   (head_tok)
	);

	// Parser state machine plus result register
	clp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_tok     (head_tok),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.frame_valid  (frame_valid),
		.frame_id     (frame_id),
		.is_extended  (is_extended),
		.byte_count   (byte_count),
		.payload      (payload)
	);

endmodule
